>>> hw/rtl/wvs_pkg.sv
// shared types, widths and constants for the weighted vruntime scheduler
`timescale 1ns / 1ps

package wvs_pkg;

  localparam int ID_W            = 22;
  localparam int CLS_W           = 3;
  localparam int RT_W            = 40;
  localparam int WEIGHT_W        = 24;
  localparam int STATUS_W        = 2;
  localparam int NUM_WEIGHT_REGS = 5;
  localparam int NUM_CLASSES     = 5;
  localparam int MAX_TASKS_DEF   = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int IN_DATA_W       = 32;
  localparam int OUT_DATA_W      = 32;

  // reset weights: 0.64, 0.8, 1, 1.25, 1.5625 in Q8.16, class 0 in the low slot
  localparam logic [NUM_WEIGHT_REGS-1:0][WEIGHT_W-1:0] WEIGHT_RESET = {
    24'd102400, 24'd81920, 24'd65536, 24'd52429, 24'd41943
  };

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_IDLE = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [RT_W-1:0]  rt;
    logic [CLS_W-1:0] cls;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic add;
    logic charge;
    logic update;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/weighted_vruntime_scheduler.sv
// top level of the weighted vruntime scheduler: controller plus datapath
`timescale 1ns / 1ps

// Fair-share task picker with a runtime-sorted ready queue of MAX_TASKS entries.
// in_* carries one command word: in_tuser is the command (add task or tick),
// in_tdata holds task_id in [21:0] and weight_class in [24:22].
// out_* returns one result word per command: status in [1:0], run_valid in [2]
// and the running task id in [24:3] (zero when nothing runs).
// cfg_we/cfg_index/cfg_data write the five Q8.16 class weights; the user must
// write them only while idle; the block itself does not enforce this. A tick
// passes through the saturating runtime adder and then the queue shift, which
// removes the head and, on a swap, reinserts the charged task in the same cycle.
// A result is loaded in S_DONE when room allows, shows on out_tvalid and sits
// in an output register; the next word is accepted while it waits. When the
// receiver stalls with a result still held, the block stops before loading the
// following result and holds in_tready low after accepting that word.
// Reset (synchronous, rst_n low) empties the queue, clears the running task
// and restores the default weights; no clearing pass is needed.
module weighted_vruntime_scheduler #(
  parameter int MAX_TASKS = wvs_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wvs_pkg::IN_DATA_W-1:0]  in_tdata,   // task_id, weight_class
  input  logic                           in_tuser,   // cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wvs_pkg::OUT_DATA_W-1:0] out_tdata,  // status, run_valid, run_id
  input  logic                           cfg_we,
  input  logic [wvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wvs_pkg::WEIGHT_W-1:0]   cfg_data
);

  wvs_pkg::ctrl_cmd_t cmd;
  wvs_pkg::dp_stat_t  stat;

  wvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wvs_datapath #(
    .MAX_TASKS(MAX_TASKS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hw/rtl/wvs_sort_queue.sv
// shift-register ready queue sorted by runtime; pop head and insert in the same cycle
`timescale 1ns / 1ps

module wvs_sort_queue #(
  parameter int MAX_TASKS = wvs_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop,
  input  logic                           ins,
  input  wvs_pkg::entry_t                new_ent,
  output wvs_pkg::entry_t                head,
  output logic [$clog2(MAX_TASKS+1)-1:0] count
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  wvs_pkg::entry_t q_r   [MAX_TASKS];
  wvs_pkg::entry_t q_nxt [MAX_TASKS];
  wvs_pkg::entry_t src   [MAX_TASKS];
  logic [MAX_TASKS-1:0] le;
  logic [CNT_W-1:0] count_r, count_nxt, cnt_src;

  assign cnt_src   = count_r - CNT_W'(pop);
  assign count_nxt = cnt_src + CNT_W'(ins);

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_ent
    // queue after an optional head removal
    if (i < MAX_TASKS - 1) begin : g_shift
      assign src[i] = pop ? q_r[i+1] : q_r[i];
    end else begin : g_last
      assign src[i] = q_r[i];
    end

    // entries at or below the new runtime form a prefix and stay in place
    assign le[i] = (CNT_W'(i) < cnt_src) && (src[i].rt <= new_ent.rt);

    if (i == 0) begin : g_first
      assign q_nxt[i] = (ins && !le[i]) ? new_ent : src[i];
    end else begin : g_rest
      always_comb begin
        if (!ins || le[i]) begin
          q_nxt[i] = src[i];
        end else if (le[i-1]) begin
          q_nxt[i] = new_ent;
        end else begin
          q_nxt[i] = src[i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (pop || ins) begin
        q_r[i] <= q_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = q_r[0];
  assign count = count_r;

endmodule

>>> hw/rtl/wvs_datapath.sv
// datapath: item latch, weight registers, running task, runtime charge and result register
`timescale 1ns / 1ps

module wvs_datapath #(
  parameter int MAX_TASKS = wvs_pkg::MAX_TASKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wvs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wvs_pkg::WEIGHT_W-1:0]     cfg_data,
  input  logic [wvs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  input  wvs_pkg::ctrl_cmd_t               cmd,
  output wvs_pkg::dp_stat_t                stat,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wvs_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ID_W  = wvs_pkg::ID_W;
  localparam int CLS_W = wvs_pkg::CLS_W;
  localparam int RT_W  = wvs_pkg::RT_W;
  localparam int W_W   = wvs_pkg::WEIGHT_W;
  localparam int NW    = wvs_pkg::NUM_WEIGHT_REGS;
  localparam int RES_W = wvs_pkg::STATUS_W + 1 + ID_W;
  localparam logic [wvs_pkg::CFG_IDX_W-1:0] CFG_IDX_LIMIT = wvs_pkg::CFG_IDX_W'(NW);

  logic                        item_tick_r;
  logic [ID_W-1:0]             item_id_r;
  logic [CLS_W-1:0]            item_cls_r, cls_in, cls_clamped;
  logic [NW-1:0][W_W-1:0]      weights_r;
  logic                        run_valid_r;
  logic [ID_W-1:0]             run_id_r;
  logic [RT_W-1:0]             run_rt_r, charged;
  logic [CLS_W-1:0]            run_cls_r;
  wvs_pkg::status_t            status_r, status_nxt;
  logic                        out_valid_r;
  logic [RES_W-1:0]            out_res_r;
  logic [W_W-1:0]              run_weight;
  logic [RT_W:0]               sum;

  logic                        q_pop, q_ins, q_full, q_empty, swap, take_head;
  wvs_pkg::entry_t             q_new, q_head;
  logic [CNT_W-1:0]            q_count;

  wvs_sort_queue #(
    .MAX_TASKS(MAX_TASKS)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop     (q_pop),
    .ins     (q_ins),
    .new_ent (q_new),
    .head    (q_head),
    .count   (q_count)
  );

  assign cls_in      = in_tdata[ID_W +: CLS_W];
  assign cls_clamped = (cls_in >= CLS_W'(wvs_pkg::NUM_CLASSES)) ?
                       CLS_W'(wvs_pkg::NUM_CLASSES - 1) : cls_in;

  // saturating runtime charge
  assign run_weight = (run_cls_r < CLS_W'(NW)) ? weights_r[run_cls_r] : '0;
  assign sum        = {1'b0, run_rt_r} + (RT_W+1)'(run_weight);
  assign charged    = sum[RT_W] ? '1 : sum[RT_W-1:0];

  assign q_full  = (q_count == CNT_W'(MAX_TASKS));
  assign q_empty = (q_count == '0);
  assign swap    = run_valid_r && !q_empty && (q_head.rt <= run_rt_r);
  assign take_head = swap || (!run_valid_r && !q_empty);

  always_comb begin
    q_pop      = 1'b0;
    q_ins      = 1'b0;
    q_new      = '{id: item_id_r, rt: '0, cls: item_cls_r};
    status_nxt = status_r;
    if (cmd.add) begin
      q_ins      = !q_full;
      status_nxt = q_full ? wvs_pkg::ST_FULL : wvs_pkg::ST_OK;
    end else if (cmd.update) begin
      // charged task goes back behind equal runtimes while the head takes over
      q_new      = '{id: run_id_r, rt: run_rt_r, cls: run_cls_r};
      q_pop      = take_head;
      q_ins      = swap;
      status_nxt = (!run_valid_r && q_empty) ? wvs_pkg::ST_IDLE : wvs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_tick_r <= (in_tuser == wvs_pkg::CMD_TICK);
      item_id_r   <= in_tdata[ID_W-1:0];
      item_cls_r  <= cls_clamped;
    end
    status_r <= status_nxt;
    out_res_r <= cmd.load ? {(run_valid_r ? run_id_r : '0), run_valid_r, status_r} : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r   <= wvs_pkg::WEIGHT_RESET;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
      run_rt_r    <= '0;
      run_cls_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index < CFG_IDX_LIMIT)) begin
        weights_r[cfg_index] <= cfg_data;
      end
      if (cmd.charge && run_valid_r) begin
        run_rt_r <= charged;
      end
      if (cmd.update && take_head) begin
        run_valid_r <= 1'b1;
        run_id_r    <= q_head.id;
        run_rt_r    <= q_head.rt;
        run_cls_r   <= q_head.cls;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.is_tick  = item_tick_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = wvs_pkg::OUT_DATA_W'(out_res_r);

endmodule

>>> hw/rtl/wvs_ctrl.sv
// controller: sequences accept, add or charge, queue update, result load per word
`timescale 1ns / 1ps

module wvs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  wvs_pkg::dp_stat_t  stat,
  output wvs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.latch  = in_tvalid && in_tready_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_tick) begin
          cmd.charge = 1'b1;
          state_nxt  = S_UPDATE;
        end else begin
          cmd.add   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // wait for room in the result register
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

endmodule

>>> dv/weighted_vruntime_scheduler_test.sv
// self-checking testbench for the weighted vruntime scheduler
`timescale 1ns / 1ps

module weighted_vruntime_scheduler_test;
  import wvs_pkg::*;

  localparam int MAX_TASKS      = MAX_TASKS_DEF;
  localparam int NUM_CFG_SLOTS  = 1 << CFG_IDX_W;
  localparam int RUN_VALID_BIT  = STATUS_W;
  localparam int RUN_ID_LSB     = STATUS_W + 1;
  localparam int TOP_CLASS      = NUM_CLASSES - 1;
  // ticks for a lone task at the largest weight
  localparam int SOLO_TICKS     = 40;
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_REPORTS    = 30;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    status_t         status;
    logic            run_valid;
    logic [ID_W-1:0] run_id;
  } pick_t;

  class pick_scoreboard;
    logic [WEIGHT_W-1:0] weight [NUM_WEIGHT_REGS];
    logic [ID_W-1:0]     rq_id  [MAX_TASKS];
    logic [RT_W-1:0]     rq_rt  [MAX_TASKS];
    logic [CLS_W-1:0]    rq_cls [MAX_TASKS];
    int unsigned         rq_len;
    logic                cur_valid;
    logic [ID_W-1:0]     cur_id;
    logic [RT_W-1:0]     cur_rt;
    logic [CLS_W-1:0]    cur_cls;
    pick_t               expected_picks [$];
    int unsigned         mismatches, words_in, picks_checked;
    int unsigned         full_adds, idle_ticks, clamped_charges;

    function new();
      for (int c = 0; c < NUM_WEIGHT_REGS; c++) weight[c] = WEIGHT_RESET[c];
      rq_len = 0;
      cur_valid = 1'b0;
      cur_id = '0;
      cur_rt = '0;
      cur_cls = '0;
      mismatches = 0;
      words_in = 0;
      picks_checked = 0;
      full_adds = 0;
      idle_ticks = 0;
      clamped_charges = 0;
    endfunction

    function void set_weight(int idx, logic [WEIGHT_W-1:0] value);
      if (idx < NUM_WEIGHT_REGS) weight[idx] = value;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    function int task_total();
      return int'(rq_len) + (cur_valid ? 1 : 0);
    endfunction

    function logic [WEIGHT_W-1:0] class_weight(logic [CLS_W-1:0] cls);
      if (cls < NUM_WEIGHT_REGS) return weight[cls];
      return '0;
    endfunction

    // goes behind every entry whose runtime is not larger
    function void enqueue_sorted(logic [ID_W-1:0] id, logic [RT_W-1:0] rt,
                                 logic [CLS_W-1:0] cls);
      int unsigned pos;
      pos = 0;
      while (pos < rq_len && rq_rt[pos] <= rt) pos++;
      for (int unsigned i = rq_len; i > pos; i--) begin
        rq_id[i]  = rq_id[i-1];
        rq_rt[i]  = rq_rt[i-1];
        rq_cls[i] = rq_cls[i-1];
      end
      rq_id[pos]  = id;
      rq_rt[pos]  = rt;
      rq_cls[pos] = cls;
      rq_len++;
    endfunction

    function void promote_head();
      cur_valid = 1'b1;
      cur_id    = rq_id[0];
      cur_rt    = rq_rt[0];
      cur_cls   = rq_cls[0];
      for (int unsigned i = 1; i < rq_len; i++) begin
        rq_id[i-1]  = rq_id[i];
        rq_rt[i-1]  = rq_rt[i];
        rq_cls[i-1] = rq_cls[i];
      end
      rq_len--;
    endfunction

    function void note_command(logic cmd, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls);
      pick_t            p;
      logic [CLS_W-1:0] eff_cls;
      logic [RT_W:0]    sum;
      logic [ID_W-1:0]  old_id;
      logic [CLS_W-1:0] old_cls;
      p.status = ST_OK;
      words_in++;
      if (cmd == CMD_ADD) begin
        eff_cls = (cls >= NUM_CLASSES) ? CLS_W'(NUM_CLASSES - 1) : cls;
        if (rq_len >= MAX_TASKS) begin
          p.status = ST_FULL;
          full_adds++;
        end else begin
          enqueue_sorted(id, '0, eff_cls);
        end
      end else if (cur_valid) begin
        sum = cur_rt + class_weight(cur_cls);
        if (sum[RT_W]) clamped_charges++;
        cur_rt = sum[RT_W] ? '1 : sum[RT_W-1:0];
        if (rq_len > 0 && rq_rt[0] <= cur_rt) begin
          old_id  = cur_id;
          old_cls = cur_cls;
          sum[RT_W-1:0] = cur_rt;
          promote_head();
          enqueue_sorted(old_id, sum[RT_W-1:0], old_cls);
        end
      end else if (rq_len > 0) begin
        promote_head();
      end else begin
        p.status = ST_IDLE;
        idle_ticks++;
      end
      p.run_valid = cur_valid;
      p.run_id    = cur_valid ? cur_id : '0;
      expected_picks.push_back(p);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 picks_checked, what, got, want);
    endtask

    task check_pick(logic [OUT_DATA_W-1:0] word);
      pick_t want;
      if (expected_picks.size() == 0) begin
        report_mismatch("word with nothing expected", word, 0);
        return;
      end
      want = expected_picks.pop_front();
      picks_checked++;
      if (word[STATUS_W-1:0] !== want.status)
        report_mismatch("status", word[STATUS_W-1:0], want.status);
      if (word[RUN_VALID_BIT] !== want.run_valid)
        report_mismatch("run_valid", word[RUN_VALID_BIT], want.run_valid);
      if (word[RUN_ID_LSB +: ID_W] !== want.run_id)
        report_mismatch("run_id", word[RUN_ID_LSB +: ID_W], want.run_id);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WEIGHT_W-1:0]   cfg_data;

  pick_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    stall_request = 0;
  int unsigned    cycle_count = 0;

  weighted_vruntime_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // results are checked before the word accepted at the same edge is predicted
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pick(out_tdata);
      if (in_tvalid && in_tready)
        sb.note_command(in_tuser, in_tdata[ID_W-1:0], in_tdata[ID_W +: CLS_W]);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random backpressure, plus a long hold when asked
  initial begin
    int unsigned hold;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request != 0) begin
        hold = stall_request;
        stall_request = 0;
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic cmd, input logic [ID_W-1:0] id,
                           input logic [CLS_W-1:0] cls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W - ID_W - CLS_W){1'b0}}, cls, id};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [WEIGHT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    @(negedge clk);
    sb.set_weight(idx, value);
  endtask

  // indexes past the last weight get junk, which must be ignored
  task automatic program_weights(input logic [WEIGHT_W-1:0] w [NUM_WEIGHT_REGS]);
    for (int r = 0; r < NUM_CFG_SLOTS; r++) begin
      if (r < NUM_WEIGHT_REGS) write_reg(r, w[r]);
      else write_reg(r, WEIGHT_W'($urandom));
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_words(input int count);
    logic             cmd;
    logic [ID_W-1:0]  id;
    logic [CLS_W-1:0] cls;
    int unsigned      add_pct;
    for (int k = 0; k < count; k++) begin
      // adds are mostly useful until the queue is full
      add_pct = (sb.task_total() <= MAX_TASKS) ? 45 : 12;
      cmd = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_TICK;
      if ($urandom_range(7) == 0) id = $urandom_range(1) ? '1 : '0;
      else id = ID_W'($urandom);
      cls = CLS_W'($urandom_range(7));
      send_word(cmd, id, cls);
    end
  endtask

  initial begin
    logic [WEIGHT_W-1:0] w [NUM_WEIGHT_REGS];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_ADD;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // nothing to run yet
    send_word(CMD_TICK, '0, '0);
    send_word(CMD_TICK, '1, '1);
    wait_for_results();

    // one task alone at the largest weight keeps running tick after tick
    write_reg(TOP_CLASS, '1);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_word(CMD_ADD, 22'h1E3C5A, CLS_W'(TOP_CLASS));
    repeat (SOLO_TICKS) send_word(CMD_TICK, '0, '0);
    wait_for_results();

    // classes 0 to 3 still at reset weights; equal runtimes and clamped classes
    send_word(CMD_ADD, '0, 3'd0);
    send_word(CMD_ADD, '1, 3'd7);
    send_word(CMD_ADD, 22'h155555, 3'd5);
    send_word(CMD_ADD, 22'h2AAAAA, 3'd6);
    send_word(CMD_ADD, 22'd1, 3'd1);
    send_word(CMD_ADD, 22'd2, 3'd2);
    send_word(CMD_ADD, 22'd3, 3'd3);
    repeat (12) send_word(CMD_TICK, '1, '1);
    send_word(CMD_ADD, 22'h3FFFFE, 3'd4);
    repeat (4) send_word(CMD_TICK, '0, '0);
    wait_for_results();

    send_idle_pct = 13;
    recv_idle_pct = 79;
    w = '{24'd0, 24'd1, 24'hFFFFFF, 24'd65536, 24'd65536};
    program_weights(w);
    random_words(370);
    wait_for_results();

    send_idle_pct = 79;
    recv_idle_pct = 13;
    for (int r = 0; r < NUM_WEIGHT_REGS; r++)
      w[r] = ($urandom_range(2) == 0) ? WEIGHT_W'($urandom_range(255)) : WEIGHT_W'($urandom);
    program_weights(w);
    random_words(370);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    w = '{24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'd0, 24'hFFFFFF};
    program_weights(w);
    random_words(300);
    // output held off while words keep coming, so the input has to stall
    stall_request = 400;
    random_words(60);
    wait_for_results();

    $display("%0d command words: %0d full-queue adds, %0d idle ticks, %0d results compared",
             sb.words_in, sb.full_adds, sb.idle_ticks, sb.picks_checked);
    $display("%0d runtime charges clamped at the ceiling, %0d mismatches",
             sb.clamped_charges, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/wvs_pkg.sv
hw/rtl/wvs_sort_queue.sv
hw/rtl/wvs_datapath.sv
hw/rtl/wvs_ctrl.sv
hw/rtl/weighted_vruntime_scheduler.sv
dv/weighted_vruntime_scheduler_test.sv
